/* rtl/http_request_stream_parser_defines.svh */
// Assertion macros shared by the HTTP request stream parser RTL.
`ifndef HTTP_REQUEST_STREAM_PARSER_DEFINES_SVH
`define HTTP_REQUEST_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HRSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hrsp assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HRSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hrsp assertion failed");

`endif

/* rtl/hrsp_pkg.sv */
// Types, codes and header-name tables for the HTTP request stream parser.
package hrsp_pkg;

    localparam int unsigned POSITION_BITS_DEFAULT = 12;
    localparam int unsigned FIELD_BITS = 12;

    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;

    // Byte classes.
    localparam logic [2:0] CLS_REQ_LINE = 3'd0;
    localparam logic [2:0] CLS_TERM     = 3'd1;
    localparam logic [2:0] CLS_NAME     = 3'd2;
    localparam logic [2:0] CLS_HOST     = 3'd3;
    localparam logic [2:0] CLS_CONN     = 3'd4;
    localparam logic [2:0] CLS_AUTH     = 3'd5;
    localparam logic [2:0] CLS_OTHER    = 3'd6;
    localparam logic [2:0] CLS_BODY     = 3'd7;

    // Status codes.
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BARE_CR      = 3'd1;
    localparam logic [2:0] ST_CR_AT_END    = 3'd2;
    localparam logic [2:0] ST_NO_BLANK     = 3'd3;
    localparam logic [2:0] ST_NO_REQ_LINE  = 3'd4;
    localparam logic [2:0] ST_UNTERMINATED = 3'd5;

    // Header kinds; a kind plus CLS_NAME gives the value class.
    localparam logic [1:0] HDR_OTHER = 2'd0;
    localparam logic [1:0] HDR_HOST  = 2'd1;
    localparam logic [1:0] HDR_CONN  = 2'd2;
    localparam logic [1:0] HDR_AUTH  = 2'd3;

    localparam int unsigned HOST_LEN = 5;
    localparam int unsigned CONN_LEN = 11;
    localparam int unsigned AUTH_LEN = 14;
    localparam logic [8*HOST_LEN-1:0] HOST_TEXT = "host:";
    localparam logic [8*CONN_LEN-1:0] CONN_TEXT = "connection:";
    localparam logic [8*AUTH_LEN-1:0] AUTH_TEXT = "authorization:";

    typedef enum logic [4:0] {
        PH_RL0   = 5'b00001,
        PH_RL1   = 5'b00010,
        PH_NAME  = 5'b00100,
        PH_VALUE = 5'b01000,
        PH_HALT  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_request;
    } in_item_t;

    typedef struct packed {
        logic [7:0]            byte_echo;
        logic [2:0]            byte_class;
        logic                  request_line_done;
        logic [FIELD_BITS-1:0] method_end;
        logic [FIELD_BITS-1:0] uri_start;
        logic [FIELD_BITS-1:0] uri_end;
        logic [FIELD_BITS-1:0] version_start;
        logic [2:0]            status;
        logic                  last_out;
    } out_item_t;

    function automatic logic [7:0] to_lower(logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    // Length of the name of header candidate k (0 host, 1 connection, 2 authorization).
    function automatic logic [3:0] hdr_len(logic [1:0] k);
        logic [3:0] len;
        len = 4'd0;
        unique case (k)
            2'd0:    len = 4'(HOST_LEN);
            2'd1:    len = 4'(CONN_LEN);
            2'd2:    len = 4'(AUTH_LEN);
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    // True when lowered byte c equals character i of candidate k's name.
    function automatic logic hdr_char_match(logic [1:0] k, logic [3:0] i, logic [7:0] c);
        int  idx;
        logic hit;
        idx = int'(i);
        hit = 1'b0;
        unique case (k)
            2'd0: begin
                if (idx < HOST_LEN) begin
                    hit = (c == HOST_TEXT[8*(HOST_LEN-1-idx) +: 8]);
                end
            end
            2'd1: begin
                if (idx < CONN_LEN) begin
                    hit = (c == CONN_TEXT[8*(CONN_LEN-1-idx) +: 8]);
                end
            end
            2'd2: begin
                if (idx < AUTH_LEN) begin
                    hit = (c == AUTH_TEXT[8*(AUTH_LEN-1-idx) +: 8]);
                end
            end
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

/* rtl/http_request_stream_parser.sv */
// HTTP request byte tagger: classifies each byte and reports request-line offsets.
//
//  Channel   Ports                        Direction  Payload
//  input     s_valid, s_ready, s_data     in         data_byte, end_of_request
//  result    m_valid, m_ready, m_data     out        byte tag, offsets, status
//
//  One byte per cycle sustained while m_ready keeps the result register draining.
//  A byte waits in the input register, updates the parser state in one pass and lands in
//  the result register, so the state loop through that pass sets the rate.
//  Reset (aresetn low, synchronous) empties both registers and returns the parser to the
//  request-line phase; the final byte of a request does the same to the parser state.
//  A stalled result register holds its byte and stops the input register from advancing.
`include "http_request_stream_parser_defines.svh"

module http_request_stream_parser #(
    parameter int unsigned POSITION_BITS = hrsp_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hrsp_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hrsp_pkg::out_item_t  m_data
);

    typedef logic [POSITION_BITS-1:0] pos_t;
    localparam pos_t POS_MAX = {POSITION_BITS{1'b1}};

    // Pipeline registers.
    logic                in_valid_reg, in_valid_next;
    hrsp_pkg::in_item_t  in_data_reg;
    logic                out_valid_reg, out_valid_next;
    hrsp_pkg::out_item_t out_data_reg, out_data_next;
    logic                advance;

    // Parser state.
    pos_t             pos_reg, pos_next;
    hrsp_pkg::phase_t phase_reg, phase_next;
    logic             pending_cr_reg, pending_cr_next;
    logic [1:0]       blp_reg, blp_next;
    logic [2:0]       flags_reg, flags_next;
    logic [3:0]       name_pos_reg, name_pos_next;
    logic [1:0]       kind_reg, kind_next;
    logic             value_started_reg, value_started_next;
    pos_t             me_reg, me_next;
    pos_t             us_reg, us_next;
    pos_t             brs_reg, brs_next;
    pos_t             lbp_reg, lbp_next;
    logic             in_blank_run_reg, in_blank_run_next;
    logic [2:0]       err_reg, err_next;
    logic             in_body_reg, in_body_next;

    function automatic pos_t sat_inc(pos_t v);
        return (v == POS_MAX) ? v : v + pos_t'(1);
    endfunction

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        logic [7:0] b;
        logic [7:0] lb;
        logic       last;
        pos_t       pos;
        logic [2:0] cls;
        logic       done;
        pos_t       me, us, ue, vs;
        pos_t       e, us_now;
        logic       enter_body, line_done, cr_set;
        logic [2:0] nf;
        logic [1:0] hit;

        b          = in_data_reg.data_byte;
        last       = in_data_reg.end_of_request;
        lb         = hrsp_pkg::to_lower(b);
        pos        = pos_reg;
        cls        = hrsp_pkg::CLS_OTHER;
        done       = 1'b0;
        me         = '0;
        us         = '0;
        ue         = '0;
        vs         = '0;
        e          = '0;
        us_now     = '0;
        enter_body = 1'b0;
        line_done  = 1'b0;
        cr_set     = 1'b0;
        nf         = 3'b000;
        hit        = hrsp_pkg::HDR_OTHER;

        phase_next         = phase_reg;
        pending_cr_next    = pending_cr_reg;
        blp_next           = blp_reg;
        flags_next         = flags_reg;
        name_pos_next      = name_pos_reg;
        kind_next          = kind_reg;
        value_started_next = value_started_reg;
        me_next            = me_reg;
        us_next            = us_reg;
        brs_next           = brs_reg;
        lbp_next           = lbp_reg;
        in_blank_run_next  = in_blank_run_reg;
        err_next           = err_reg;
        in_body_next       = in_body_reg;

        // Track progress through CR LF CR LF on the raw stream.
        if (!in_body_reg) begin
            if (b == hrsp_pkg::CH_CR) begin
                blp_next = (blp_reg == 2'd2) ? 2'd3 : 2'd1;
            end else if (b == hrsp_pkg::CH_LF) begin
                if (blp_reg == 2'd1) begin
                    blp_next = 2'd2;
                end else begin
                    enter_body = (blp_reg == 2'd3);
                    blp_next   = 2'd0;
                end
            end else begin
                blp_next = 2'd0;
            end
        end

        if (in_body_reg) begin
            cls = hrsp_pkg::CLS_BODY;
        end else if (phase_reg == hrsp_pkg::PH_HALT) begin
            cls = hrsp_pkg::CLS_OTHER;
        end else if (pending_cr_reg) begin
            pending_cr_next = 1'b0;
            if (b == hrsp_pkg::CH_LF) begin
                cls       = hrsp_pkg::CLS_TERM;
                line_done = 1'b1;
                if (phase_reg == hrsp_pkg::PH_RL0) begin
                    done = 1'b1;
                    if (err_reg == hrsp_pkg::ST_OK) begin
                        err_next = hrsp_pkg::ST_NO_BLANK;
                    end
                    phase_next = hrsp_pkg::PH_NAME;
                end else if (phase_reg == hrsp_pkg::PH_RL1) begin
                    // The line ends just before the CR; an empty URI sits at that end.
                    e          = (pos != '0) ? pos - pos_t'(1) : '0;
                    us_now     = (us_reg > me_reg) ? us_reg : e;
                    done       = 1'b1;
                    me         = me_reg;
                    vs         = sat_inc(lbp_reg);
                    us         = us_now;
                    ue         = (brs_reg == me_reg) ? us_now : brs_reg;
                    phase_next = hrsp_pkg::PH_NAME;
                end else if (phase_reg == hrsp_pkg::PH_NAME && name_pos_reg == 4'd0) begin
                    phase_next = hrsp_pkg::PH_HALT;
                end else begin
                    phase_next = hrsp_pkg::PH_NAME;
                end
                flags_next         = 3'b111;
                name_pos_next      = 4'd0;
                kind_next          = hrsp_pkg::HDR_OTHER;
                value_started_next = 1'b0;
            end else begin
                if (err_reg == hrsp_pkg::ST_OK) begin
                    err_next = hrsp_pkg::ST_BARE_CR;
                end
                phase_next = hrsp_pkg::PH_HALT;
                cls        = hrsp_pkg::CLS_OTHER;
            end
        end else if (b == hrsp_pkg::CH_CR) begin
            pending_cr_next = 1'b1;
            cr_set          = 1'b1;
            cls             = hrsp_pkg::CLS_TERM;
        end else if (phase_reg == hrsp_pkg::PH_RL0 || phase_reg == hrsp_pkg::PH_RL1) begin
            cls = hrsp_pkg::CLS_REQ_LINE;
            if (hrsp_pkg::is_blank(b)) begin
                if (!in_blank_run_reg) begin
                    brs_next = pos;
                    if (phase_reg == hrsp_pkg::PH_RL0) begin
                        me_next    = pos;
                        phase_next = hrsp_pkg::PH_RL1;
                    end
                    in_blank_run_next = 1'b1;
                end
                lbp_next = pos;
            end else if (in_blank_run_reg) begin
                in_blank_run_next = 1'b0;
                if (us_reg <= me_reg) begin
                    us_next = pos;
                end
            end
        end else if (phase_reg == hrsp_pkg::PH_NAME) begin
            // Three candidates compared in parallel; the longest name wins a tie.
            for (int k = 0; k < 3; k++) begin
                if (flags_reg[k] && hrsp_pkg::hdr_char_match(2'(k), name_pos_reg, lb)) begin
                    nf[k] = 1'b1;
                    if ({1'b0, name_pos_reg} + 5'd1 == {1'b0, hrsp_pkg::hdr_len(2'(k))}) begin
                        hit = 2'(k + 1);
                    end
                end
            end
            name_pos_next = (name_pos_reg != 4'd15) ? name_pos_reg + 4'd1 : 4'd15;
            flags_next    = nf;
            if (hit != hrsp_pkg::HDR_OTHER) begin
                kind_next          = hit;
                phase_next         = hrsp_pkg::PH_VALUE;
                value_started_next = 1'b0;
                cls                = hrsp_pkg::CLS_NAME;
            end else if (nf == 3'b000) begin
                kind_next          = hrsp_pkg::HDR_OTHER;
                phase_next         = hrsp_pkg::PH_VALUE;
                value_started_next = 1'b1;
                cls                = hrsp_pkg::CLS_OTHER;
            end else begin
                cls = hrsp_pkg::CLS_NAME;
            end
        end else begin
            if (kind_reg == hrsp_pkg::HDR_OTHER) begin
                cls = hrsp_pkg::CLS_OTHER;
            end else if (!value_started_reg && hrsp_pkg::is_blank(b)) begin
                cls = hrsp_pkg::CLS_NAME;
            end else begin
                value_started_next = 1'b1;
                cls                = hrsp_pkg::CLS_NAME + {1'b0, kind_reg};
            end
        end

        if (enter_body) begin
            in_body_next = 1'b1;
        end

        if (last && !in_body_reg && !in_body_next && err_next == hrsp_pkg::ST_OK
                && phase_next != hrsp_pkg::PH_HALT) begin
            if (cr_set) begin
                err_next = hrsp_pkg::ST_CR_AT_END;
            end else if (phase_next == hrsp_pkg::PH_RL0 || phase_next == hrsp_pkg::PH_RL1) begin
                err_next = hrsp_pkg::ST_NO_REQ_LINE;
            end else if (!line_done) begin
                err_next = hrsp_pkg::ST_UNTERMINATED;
            end
        end

        pos_next = sat_inc(pos);

        out_data_next.byte_echo         = b;
        out_data_next.byte_class        = cls;
        out_data_next.request_line_done = done;
        out_data_next.method_end        = hrsp_pkg::FIELD_BITS'(me);
        out_data_next.uri_start         = hrsp_pkg::FIELD_BITS'(us);
        out_data_next.uri_end           = hrsp_pkg::FIELD_BITS'(ue);
        out_data_next.version_start     = hrsp_pkg::FIELD_BITS'(vs);
        out_data_next.status            = err_next;
        out_data_next.last_out          = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // Parser state moves once per byte; the final byte of a request restores reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_data_reg.end_of_request)) begin
            pos_reg           <= '0;
            phase_reg         <= hrsp_pkg::PH_RL0;
            pending_cr_reg    <= 1'b0;
            blp_reg           <= 2'd0;
            flags_reg         <= 3'b111;
            name_pos_reg      <= 4'd0;
            kind_reg          <= hrsp_pkg::HDR_OTHER;
            value_started_reg <= 1'b0;
            me_reg            <= '0;
            us_reg            <= '0;
            brs_reg           <= '0;
            lbp_reg           <= '0;
            in_blank_run_reg  <= 1'b0;
            err_reg           <= hrsp_pkg::ST_OK;
            in_body_reg       <= 1'b0;
        end else if (advance) begin
            pos_reg           <= pos_next;
            phase_reg         <= phase_next;
            pending_cr_reg    <= pending_cr_next;
            blp_reg           <= blp_next;
            flags_reg         <= flags_next;
            name_pos_reg      <= name_pos_next;
            kind_reg          <= kind_next;
            value_started_reg <= value_started_next;
            me_reg            <= me_next;
            us_reg            <= us_next;
            brs_reg           <= brs_next;
            lbp_reg           <= lbp_next;
            in_blank_run_reg  <= in_blank_run_next;
            err_reg           <= err_next;
            in_body_reg       <= in_body_next;
        end
    end

    `HRSP_ASSERT_NOW(a_done_on_terminator, m_valid && m_data.request_line_done, m_data.byte_class == hrsp_pkg::CLS_TERM)
    `HRSP_ASSERT_NOW(a_offsets_zero_idle, m_valid && !m_data.request_line_done, (m_data.method_end == '0) && (m_data.uri_start == '0) && (m_data.uri_end == '0) && (m_data.version_start == '0))
    `HRSP_ASSERT_NEXT(a_last_restarts, advance && in_data_reg.end_of_request, (pos_reg == '0) && (phase_reg == hrsp_pkg::PH_RL0) && (err_reg == hrsp_pkg::ST_OK))
    `HRSP_ASSERT_NOW(a_body_after_blank_line, in_body_reg, (blp_reg == 2'd0) && (err_reg != hrsp_pkg::ST_CR_AT_END))

endmodule
